@@ src/pls_pkg.sv @@
// shared types, constants and helpers of the pixel line scaler
package pls_pkg;

   localparam int MAX_LINE_WIDTH = 1024;
   localparam int PALETTE_DEPTH  = 256;
   localparam int FB_ADDR_BITS   = 20;

   localparam int WIDTH_BITS  = 11;
   localparam int STEP_BITS   = 18;
   localparam int STRIDE_BITS = 12;
   localparam int MARGIN_BITS = 8;
   localparam int ROW_BITS    = 9;
   localparam int PIX_BITS    = 8;
   localparam int POS_BITS    = 19;
   localparam int FRAC_BITS   = 8;

   localparam int CNT_BITS = $clog2(MAX_LINE_WIDTH + 1);
   localparam int COL_BITS = $clog2(2 * MAX_LINE_WIDTH);
   localparam int CMP_BITS = ((COL_BITS > WIDTH_BITS) ? COL_BITS : WIDTH_BITS) + 1;

   localparam int PAL_ADDR_BITS = $clog2(PALETTE_DEPTH);
   localparam int CODE_CMP_BITS = PIX_BITS + 1;

   localparam int PROD_BITS = ROW_BITS + STRIDE_BITS;
   localparam int SUM_MIN_BITS = ((PROD_BITS > COL_BITS) ? PROD_BITS : COL_BITS) + 1;
   localparam int ADDR_SUM_BITS = (FB_ADDR_BITS > SUM_MIN_BITS) ? FB_ADDR_BITS : SUM_MIN_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = STEP_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_STEP   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_STRIDE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_MARGIN  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_PALETTE  = 3'd5;

   localparam logic MODE_PIXEL     = 1'b0;
   localparam logic MODE_PAL_WRITE = 1'b1;

   localparam logic [WIDTH_BITS-1:0]  SOURCE_WIDTH_RESET = 11'd352;
   localparam logic [WIDTH_BITS-1:0]  DEST_WIDTH_RESET   = 11'd352;
   localparam logic [STEP_BITS-1:0]   SCALE_STEP_RESET   = 18'd256;
   localparam logic [STRIDE_BITS-1:0] LINE_STRIDE_RESET  = 12'd412;
   localparam logic [MARGIN_BITS-1:0] LEFT_MARGIN_RESET  = 8'd60;
   localparam logic                   USE_PALETTE_RESET  = 1'b1;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   typedef struct packed {
      logic                mode;
      logic [PIX_BITS-1:0] source_value;
      logic [PIX_BITS-1:0] palette_color;
      logic [ROW_BITS-1:0] dest_row;
      logic                first_of_line;
   } req_item_type;

   typedef struct packed {
      logic [FB_ADDR_BITS-1:0] fb_address;
      logic [PIX_BITS-1:0]     pixel_color;
      logic                    end_of_line;
   } rsp_item_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  source_width;
      logic [WIDTH_BITS-1:0]  dest_width;
      logic [STEP_BITS-1:0]   scale_step;
      logic [STRIDE_BITS-1:0] line_stride;
      logic [MARGIN_BITS-1:0] left_margin;
      logic                   use_palette;
   } cfg_type;

   // what one accepted pixel asks of the output side
   typedef struct packed {
      logic                emit;
      logic                dbl;
      logic [COL_BITS-1:0] col;
      logic                last;
      logic [ROW_BITS-1:0] row;
      logic                map_pal;
      logic                code_ok;
      logic [PIX_BITS-1:0] value;
   } plan_type;

   function automatic logic [CNT_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] w);
      logic [CNT_BITS-1:0] r;
      if (CMP_BITS'(w) > CMP_BITS'(MAX_LINE_WIDTH)) begin
         r = CNT_BITS'(MAX_LINE_WIDTH);
      end else begin
         r = CNT_BITS'(w);
      end
      return r;
   endfunction

endpackage

@@ src/pls_palette.sv @@
// palette memory with one write port and one registered read port
module pls_palette (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [pls_pkg::PIX_BITS-1:0]   wr_addr,
   input  logic [pls_pkg::PIX_BITS-1:0]   wr_data,
   input  logic                           rd_en,
   input  logic [pls_pkg::PIX_BITS-1:0]   rd_addr,
   output logic [pls_pkg::PIX_BITS-1:0]   rd_data
);

   logic [pls_pkg::PIX_BITS-1:0] palette_mem [pls_pkg::PALETTE_DEPTH];
   logic [pls_pkg::PIX_BITS-1:0] pal_rd_ff;
   logic                         wr_ok;

   assign wr_ok = wr_en && (pls_pkg::CODE_CMP_BITS'(wr_addr) <
                            pls_pkg::CODE_CMP_BITS'(pls_pkg::PALETTE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         palette_mem[wr_addr[pls_pkg::PAL_ADDR_BITS-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         pal_rd_ff <= palette_mem[rd_addr[pls_pkg::PAL_ADDR_BITS-1:0]];
      end
   end

   assign rd_data = pal_rd_ff;

endmodule

@@ src/pls_line_ctrl.sv @@
// line counters and per-pixel column plan for decimate, double and centre modes
module pls_line_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  pls_pkg::req_item_type item,
   input  pls_pkg::cfg_type      cfg,
   output pls_pkg::plan_type     plan
);

   logic [pls_pkg::CNT_BITS-1:0] src_idx_ff, src_idx_in;
   logic [pls_pkg::CNT_BITS-1:0] out_col_ff, out_col_in;
   logic [pls_pkg::POS_BITS-1:0] pos_ff, pos_in;

   logic [pls_pkg::CNT_BITS-1:0] idx, oc, w, d, off;
   logic [pls_pkg::POS_BITS-1:0] pos;
   logic [pls_pkg::POS_BITS:0]   pos_sum;
   logic                         is_pixel, in_range, decimate, dbl, dec_emit;

   always_comb begin
      is_pixel = (item.mode == pls_pkg::MODE_PIXEL);
      idx = item.first_of_line ? '0 : src_idx_ff;
      oc  = item.first_of_line ? '0 : out_col_ff;
      pos = item.first_of_line ? '0 : pos_ff;
      w = pls_pkg::clamp_width(cfg.source_width);
      d = pls_pkg::clamp_width(cfg.dest_width);
      in_range = (pls_pkg::CMP_BITS'(idx) < pls_pkg::CMP_BITS'(w));
      decimate = (pls_pkg::CMP_BITS'(w) > pls_pkg::CMP_BITS'(d));
      dbl = !decimate &&
            ((pls_pkg::CMP_BITS'(w) << 1) == pls_pkg::CMP_BITS'(d));
      dec_emit = (pls_pkg::CMP_BITS'(oc) < pls_pkg::CMP_BITS'(d)) &&
                 (pls_pkg::CMP_BITS'(pos[pls_pkg::POS_BITS-1:pls_pkg::FRAC_BITS]) <=
                  pls_pkg::CMP_BITS'(idx));
      off = (d - w) >> 1;
      pos_sum = (pls_pkg::POS_BITS+1)'(pos) + (pls_pkg::POS_BITS+1)'(cfg.scale_step);

      src_idx_in = idx;
      out_col_in = oc;
      pos_in     = pos;
      if (in_range) begin
         src_idx_in = idx + 1'b1;
         if (decimate && dec_emit) begin
            out_col_in = oc + 1'b1;
            pos_in = pos_sum[pls_pkg::POS_BITS] ? pls_pkg::POS_MAX
                                                : pos_sum[pls_pkg::POS_BITS-1:0];
         end
      end

      plan.emit    = is_pixel && in_range && (!decimate || dec_emit);
      plan.dbl     = dbl;
      plan.row     = item.dest_row;
      plan.map_pal = cfg.use_palette;
      plan.code_ok = (pls_pkg::CODE_CMP_BITS'(item.source_value) <
                      pls_pkg::CODE_CMP_BITS'(pls_pkg::PALETTE_DEPTH));
      plan.value   = item.source_value;
      if (decimate) begin
         plan.col  = pls_pkg::COL_BITS'(oc);
         plan.last = ((pls_pkg::CMP_BITS'(oc) + 1'b1) == pls_pkg::CMP_BITS'(d));
      end else if (dbl) begin
         plan.col  = pls_pkg::COL_BITS'({idx, 1'b0});
         plan.last = ((pls_pkg::CMP_BITS'(idx) + 1'b1) == pls_pkg::CMP_BITS'(w));
      end else begin
         plan.col  = pls_pkg::COL_BITS'(off) + pls_pkg::COL_BITS'(idx);
         plan.last = ((pls_pkg::CMP_BITS'(idx) + 1'b1) == pls_pkg::CMP_BITS'(w));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_idx_ff <= '0;
         out_col_ff <= '0;
         pos_ff     <= '0;
      end else if (accept && is_pixel) begin
         src_idx_ff <= src_idx_in;
         out_col_ff <= out_col_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

@@ src/pls_emit.sv @@
// holding stage for one pixel, colour select, address calc and result register
module pls_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  pls_pkg::plan_type            plan,
   input  logic [pls_pkg::PIX_BITS-1:0] pal_data,
   input  pls_pkg::cfg_type             cfg,
   output logic                         ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pls_pkg::rsp_item_type        rsp_item
);

   logic                  hold_valid_ff, hold_valid_in;
   pls_pkg::plan_type     hold_ff;
   logic                  phase_ff, phase_in;
   logic                  out_valid_ff, out_valid_in;
   pls_pkg::rsp_item_type out_ff, out_in;

   logic                             out_free, hold_move, hold_done;
   logic [pls_pkg::PROD_BITS-1:0]     prod;
   logic [pls_pkg::ADDR_SUM_BITS-1:0] addr_sum;
   logic [pls_pkg::COL_BITS-1:0]      col;

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      hold_move = hold_valid_ff && out_free;
      hold_done = hold_move && (!hold_ff.dbl || phase_ff);
      ready     = !hold_valid_ff || hold_done;

      col = hold_ff.col | pls_pkg::COL_BITS'(phase_ff);
      prod = pls_pkg::PROD_BITS'(hold_ff.row) * pls_pkg::PROD_BITS'(cfg.line_stride);
      addr_sum = pls_pkg::ADDR_SUM_BITS'(prod) + pls_pkg::ADDR_SUM_BITS'(cfg.left_margin) +
                 pls_pkg::ADDR_SUM_BITS'(col);
      out_in.fb_address = addr_sum[pls_pkg::FB_ADDR_BITS-1:0];
      if (!hold_ff.map_pal) begin
         out_in.pixel_color = hold_ff.value;
      end else if (hold_ff.code_ok) begin
         out_in.pixel_color = pal_data;
      end else begin
         out_in.pixel_color = '0;
      end
      out_in.end_of_line = hold_ff.dbl ? (phase_ff && hold_ff.last) : hold_ff.last;

      if (accept) begin
         hold_valid_in = plan.emit;
      end else if (hold_done) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end

      if (accept || hold_done) begin
         phase_in = 1'b0;
      end else if (hold_move) begin
         phase_in = 1'b1;
      end else begin
         phase_in = phase_ff;
      end

      if (hold_move) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= plan;
      end
      if (hold_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

@@ src/pixel_line_scaler.sv @@
// Pixel line scaler: takes one source pixel or palette write per cycle on the
// req channel while req_stall is low, and writes framebuffer results on the
// rsp channel. Each pixel passes an input stage (line counters, palette read)
// and a holding stage that forms the address and colour into the result
// register, which it loads once that register is free. A pixel yields one
// result, except in doubling mode where it yields two through the single
// result register and the next item is taken only as the second moves on;
// palette writes and pixels that yield no result leave the holding stage empty.
// Registers must be written through the csr port only while no item is in
// flight; the block itself does not enforce this.
module pixel_line_scaler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pls_pkg::req_item_type                req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pls_pkg::rsp_item_type                rsp_item,
   input  logic                                 csr_we,
   input  logic [pls_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pls_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   pls_pkg::cfg_type  cfg_ff;
   pls_pkg::plan_type plan;
   logic [pls_pkg::PIX_BITS-1:0] pal_data;
   logic ready, accept;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width <= pls_pkg::SOURCE_WIDTH_RESET;
         cfg_ff.dest_width   <= pls_pkg::DEST_WIDTH_RESET;
         cfg_ff.scale_step   <= pls_pkg::SCALE_STEP_RESET;
         cfg_ff.line_stride  <= pls_pkg::LINE_STRIDE_RESET;
         cfg_ff.left_margin  <= pls_pkg::LEFT_MARGIN_RESET;
         cfg_ff.use_palette  <= pls_pkg::USE_PALETTE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pls_pkg::CSR_SOURCE_WIDTH: begin
               cfg_ff.source_width <= csr_wdata[pls_pkg::WIDTH_BITS-1:0];
            end
            pls_pkg::CSR_DEST_WIDTH: begin
               cfg_ff.dest_width <= csr_wdata[pls_pkg::WIDTH_BITS-1:0];
            end
            pls_pkg::CSR_SCALE_STEP: begin
               cfg_ff.scale_step <= csr_wdata[pls_pkg::STEP_BITS-1:0];
            end
            pls_pkg::CSR_LINE_STRIDE: begin
               cfg_ff.line_stride <= csr_wdata[pls_pkg::STRIDE_BITS-1:0];
            end
            pls_pkg::CSR_LEFT_MARGIN: begin
               cfg_ff.left_margin <= csr_wdata[pls_pkg::MARGIN_BITS-1:0];
            end
            pls_pkg::CSR_USE_PALETTE: begin
               cfg_ff.use_palette <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   pls_line_ctrl u_line_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .cfg    (cfg_ff),
      .plan   (plan)
   );

   pls_palette u_palette (
      .clock   (clock),
      .wr_en   (accept && (req_item.mode == pls_pkg::MODE_PAL_WRITE)),
      .wr_addr (req_item.source_value),
      .wr_data (req_item.palette_color),
      .rd_en   (accept && (req_item.mode == pls_pkg::MODE_PIXEL)),
      .rd_addr (req_item.source_value),
      .rd_data (pal_data)
   );

   pls_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .plan      (plan),
      .pal_data  (pal_data),
      .cfg       (cfg_ff),
      .ready     (ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the pixel line scaler
module testbench;
   import pls_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned STEP_MAX = (1 << STEP_BITS) - 1;
   localparam int unsigned IDLE_MAX = 17;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS = 120;
   localparam int unsigned RANDOM_PHASES = 5;

   typedef enum int unsigned {
      SCALE_DECIMATE,
      SCALE_DOUBLE,
      SCALE_CENTRE,
      SCALE_ANY
   } scale_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   rsp_item_type rsp_item;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   cfg_type shadow_cfg;
   logic [PIX_BITS-1:0] palette_shadow [PALETTE_DEPTH];
   bit palette_loaded [PALETTE_DEPTH];
   logic [PIX_BITS-1:0] loaded_codes [$];
   int unsigned line_pixel_count = 0;
   int unsigned decim_column = 0;
   logic [POS_BITS-1:0] sample_pos = '0;
   rsp_item_type fb_writes_due [$];
   rsp_item_type wanted_write;

   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;
   int unsigned writes_checked = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count = 0;
   bit send_no_idle = 1'b0;
   bit recv_no_idle = 1'b0;

   pixel_line_scaler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d writes still due", cycle_count,
               fb_writes_due.size());
      $display("Test completed with failures");
      $finish;
   end

   function automatic void queue_fb_write(input logic [ROW_BITS-1:0] row,
         input int unsigned col, input logic [PIX_BITS-1:0] colour, input bit last);
      rsp_item_type fb_write;
      logic [31:0] addr;
      addr = 32'(row) * 32'(shadow_cfg.line_stride) + 32'(shadow_cfg.left_margin) + col;
      fb_write.fb_address = addr[FB_ADDR_BITS-1:0];
      fb_write.pixel_color = colour;
      fb_write.end_of_line = last;
      fb_writes_due.push_back(fb_write);
   endfunction

   function automatic void predict_fb_writes(input req_item_type it);
      int unsigned w;
      int unsigned d;
      int unsigned i;
      int unsigned next_pos;
      logic [PIX_BITS-1:0] colour;
      if (it.mode == MODE_PAL_WRITE) begin
         palette_shadow[it.source_value] = it.palette_color;
         if (!palette_loaded[it.source_value]) begin
            palette_loaded[it.source_value] = 1'b1;
            loaded_codes.push_back(it.source_value);
         end
         return;
      end
      if (it.first_of_line) begin
         line_pixel_count = 0;
         decim_column = 0;
         sample_pos = '0;
      end
      w = (shadow_cfg.source_width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH
                                                     : shadow_cfg.source_width;
      d = (shadow_cfg.dest_width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH
                                                   : shadow_cfg.dest_width;
      if (line_pixel_count >= w) return;
      i = line_pixel_count;
      line_pixel_count = i + 1;
      colour = shadow_cfg.use_palette ? palette_shadow[it.source_value] : it.source_value;
      if (w > d) begin
         if (decim_column < d && (sample_pos >> FRAC_BITS) <= i) begin
            queue_fb_write(it.dest_row, decim_column, colour, decim_column + 1 == d);
            decim_column++;
            next_pos = sample_pos + shadow_cfg.scale_step;
            sample_pos = (next_pos > POS_MAX) ? POS_MAX : POS_BITS'(next_pos);
         end
      end else if (2 * w == d) begin
         queue_fb_write(it.dest_row, 2 * i, colour, 1'b0);
         queue_fb_write(it.dest_row, 2 * i + 1, colour, i + 1 == w);
      end else begin
         queue_fb_write(it.dest_row, (d - w) / 2 + i, colour, i + 1 == w);
      end
   endfunction

   task automatic note_mismatch(input string what, input rsp_item_type wanted,
         input rsp_item_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected addr %h colour %h eol %b, got addr %h colour %h eol %b",
                  what, wanted.fb_address, wanted.pixel_color, wanted.end_of_line,
                  got.fb_address, got.pixel_color, got.end_of_line);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         writes_checked++;
         if (fb_writes_due.size() == 0) begin
            note_mismatch("unexpected write", '0, rsp_item);
         end else begin
            wanted_write = fb_writes_due.pop_front();
            if (rsp_item.fb_address !== wanted_write.fb_address
                  || rsp_item.pixel_color !== wanted_write.pixel_color
                  || rsp_item.end_of_line !== wanted_write.end_of_line) begin
               note_mismatch("write mismatch", wanted_write, rsp_item);
            end
         end
      end
   end

   initial begin : result_sink
      int unsigned hold;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) recv_no_idle = !recv_no_idle;
         hold = recv_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   task automatic send_item(input req_item_type it);
      int unsigned gap;
      gap = send_no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item = it;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_fb_writes(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (fb_writes_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input int unsigned value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SOURCE_WIDTH: shadow_cfg.source_width = WIDTH_BITS'(value);
         CSR_DEST_WIDTH:   shadow_cfg.dest_width = WIDTH_BITS'(value);
         CSR_SCALE_STEP:   shadow_cfg.scale_step = STEP_BITS'(value);
         CSR_LINE_STRIDE:  shadow_cfg.line_stride = STRIDE_BITS'(value);
         CSR_LEFT_MARGIN:  shadow_cfg.left_margin = MARGIN_BITS'(value);
         CSR_USE_PALETTE:  shadow_cfg.use_palette = value[0];
         default: ;
      endcase
   endtask

   task automatic set_scaler(input int unsigned src_w, input int unsigned dst_w,
         input int unsigned step, input int unsigned stride, input int unsigned margin,
         input int unsigned palette_on);
      wait_drained();
      write_csr(CSR_SOURCE_WIDTH, src_w);
      write_csr(CSR_DEST_WIDTH, dst_w);
      write_csr(CSR_SCALE_STEP, step);
      write_csr(CSR_LINE_STRIDE, stride);
      write_csr(CSR_LEFT_MARGIN, margin);
      write_csr(CSR_USE_PALETTE, palette_on);
      settings_used++;
   endtask

   function automatic req_item_type pixel_item(input logic [PIX_BITS-1:0] code,
         input logic [ROW_BITS-1:0] row, input bit first);
      req_item_type it;
      it.mode = MODE_PIXEL;
      it.source_value = code;
      it.palette_color = PIX_BITS'($urandom);
      it.dest_row = row;
      it.first_of_line = first;
      return it;
   endfunction

   function automatic req_item_type palette_item(input logic [PIX_BITS-1:0] addr,
         input logic [PIX_BITS-1:0] colour);
      req_item_type it;
      it.mode = MODE_PAL_WRITE;
      it.source_value = addr;
      it.palette_color = colour;
      it.dest_row = ROW_BITS'($urandom);
      it.first_of_line = $urandom_range(0, 1);
      return it;
   endfunction

   // with the palette on, only entries already loaded are read
   function automatic logic [PIX_BITS-1:0] pick_code();
      if (!shadow_cfg.use_palette) return PIX_BITS'($urandom);
      return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
   endfunction

   task automatic test_palette_and_reset_values();
      send_item(palette_item(8'h00, 8'hE3));
      send_item(palette_item(8'hFF, 8'h1C));
      send_item(palette_item(8'hAA, 8'h55));
      send_item(palette_item(8'h55, 8'hAA));
      send_item(pixel_item(8'h00, 9'd0, 1'b1));
      send_item(pixel_item(8'hFF, 9'd511, 1'b0));
      send_item(pixel_item(8'hAA, 9'd300, 1'b0));
   endtask

   task automatic test_decimation();
      req_item_type entry;
      set_scaler(4, 3, 341, 2048, 255, 0);
      send_item(pixel_item(8'h00, 9'd511, 1'b1));
      entry = palette_item(8'h3C, 8'hC3);
      entry.first_of_line = 1'b1;
      send_item(entry);
      send_item(pixel_item(8'hFF, 9'd511, 1'b0));
      send_item(pixel_item(8'h5A, 9'd511, 1'b0));
      send_item(pixel_item(8'hA5, 9'd511, 1'b0));
      send_item(pixel_item(8'h3C, 9'd511, 1'b0));
   endtask

   task automatic test_step_extremes();
      int unsigned k;
      set_scaler(3, 2, 0, 412, 60, 1);
      for (k = 0; k < 3; k++) send_item(pixel_item(pick_code(), 9'd17, k == 0));
      set_scaler(3, 2, STEP_MAX, 412, 60, 1);
      for (k = 0; k < 3; k++) send_item(pixel_item(pick_code(), 9'd18, k == 0));
   endtask

   task automatic test_doubling();
      int unsigned k;
      set_scaler(3, 6, 256, 1, 0, 1);
      for (k = 0; k < 4; k++) send_item(pixel_item(pick_code(), 9'h155, k == 0));
   endtask

   task automatic test_centring();
      set_scaler(3, 1024, 256, 2048, 255, 0);
      send_item(pixel_item(8'h00, 9'h0AA, 1'b1));
      send_item(pixel_item(8'hFF, 9'h0AA, 1'b0));
      send_item(pixel_item(8'h81, 9'h0AA, 1'b0));
   endtask

   task automatic test_zero_widths();
      set_scaler(0, 5, 256, 412, 60, 0);
      send_item(pixel_item(8'h12, 9'd3, 1'b1));
      set_scaler(5, 0, 256, 412, 60, 0);
      send_item(pixel_item(8'h34, 9'd4, 1'b1));
   endtask

   task automatic test_full_width_line();
      int unsigned k;
      set_scaler(MAX_LINE_WIDTH, 1000, MAX_LINE_WIDTH * 256 / 1000, 2048, 255, 1);
      for (k = 0; k <= MAX_LINE_WIDTH; k++) begin
         if (k % 64 == 0) send_no_idle = ($urandom_range(0, 2) == 0);
         send_item(pixel_item(pick_code(), 9'd511, k == 0));
      end
      send_no_idle = 1'b0;
   endtask

   task automatic send_random_line(input int unsigned width, inout int unsigned count);
      int unsigned shape;
      int unsigned length;
      int unsigned k;
      logic [ROW_BITS-1:0] row;
      bit first;
      shape = $urandom_range(0, 9);
      row = ROW_BITS'($urandom);
      send_no_idle = ($urandom_range(0, 3) == 0);
      case (shape)
         7: length = width + $urandom_range(1, 3);
         8: length = $urandom_range(1, width);
         default: length = width;
      endcase
      for (k = 0; k < length; k++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_item(palette_item(PIX_BITS'($urandom), PIX_BITS'($urandom)));
            count++;
         end
         // continuation lines carry no start mark, some lines restart halfway
         first = (k == 0 && shape != 9) || (shape == 6 && k == length / 2);
         if (shape == 5) row = ROW_BITS'($urandom);
         send_item(pixel_item(pick_code(), row, first));
         count++;
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
   endtask

   task automatic test_random_lines();
      int unsigned phase;
      int unsigned src_w;
      int unsigned dst_w;
      int unsigned step;
      int unsigned stride;
      int unsigned margin;
      int unsigned phase_count;
      scale_kind_type kind;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         kind = scale_kind_type'(phase % 4);
         src_w = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                             : $urandom_range(2, 40);
         case (kind)
            SCALE_DECIMATE: begin
               dst_w = $urandom_range(1, src_w - 1);
               step = src_w * 256 / dst_w;
            end
            SCALE_DOUBLE: begin
               dst_w = 2 * src_w;
               step = $urandom_range(0, STEP_MAX);
            end
            SCALE_CENTRE: begin
               dst_w = $urandom_range(src_w, src_w + 60);
               if (dst_w == 2 * src_w) dst_w++;
               step = $urandom_range(0, STEP_MAX);
            end
            default: begin
               src_w = $urandom_range(1, 64);
               dst_w = $urandom_range(1, 64);
               step = $urandom_range(0, 1) ? $urandom_range(0, 300)
                                           : $urandom_range(0, STEP_MAX);
            end
         endcase
         if (phase == 0) begin
            stride = 1;
            margin = 0;
         end else if (phase == 1) begin
            stride = 2048;
            margin = 255;
         end else begin
            stride = $urandom_range(1, 2048);
            margin = $urandom_range(0, 255);
         end
         set_scaler(src_w, dst_w, step, stride, margin, $urandom_range(0, 1));
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) send_random_line(src_w, phase_count);
      end
   endtask

   initial begin
      shadow_cfg.source_width = SOURCE_WIDTH_RESET;
      shadow_cfg.dest_width = DEST_WIDTH_RESET;
      shadow_cfg.scale_step = SCALE_STEP_RESET;
      shadow_cfg.line_stride = LINE_STRIDE_RESET;
      shadow_cfg.left_margin = LEFT_MARGIN_RESET;
      shadow_cfg.use_palette = USE_PALETTE_RESET;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_palette_and_reset_values();
      test_decimation();
      test_step_extremes();
      test_doubling();
      test_centring();
      test_zero_widths();
      test_random_lines();
      test_full_width_line();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("%0d items sent under %0d register settings, %0d framebuffer writes checked",
               items_sent, settings_used, writes_checked);
      $display("%0d mismatches, %0d palette entries loaded", mismatch_count,
               loaded_codes.size());
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
